@@ hw/rtl/bfce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bfce_pkg;

    localparam int CharW    = 8;
    localparam int CodeW    = 5;
    localparam int BitPerW  = 10;
    localparam int StopPerW = 11;
    localparam int DurW     = 11;
    localparam int IdxW     = 4;
    localparam int SeqW     = 14;
    localparam int FrameW   = 7;

    localparam logic [BitPerW-1:0]  BitPerReset  = 10'd22;
    localparam logic [StopPerW-1:0] StopPerReset = 11'd33;
    localparam logic [BitPerW-1:0]  BitPerMax    = 10'd1000;
    localparam logic [StopPerW-1:0] StopPerMax   = 11'd1500;

    // event index of the final stop bit for one or two framed characters
    localparam logic [IdxW-1:0] LastIdxOne = 4'd6;
    localparam logic [IdxW-1:0] LastIdxTwo = 4'd13;

    localparam logic [CodeW-1:0] LtrsCode  = 5'b11111;
    localparam logic [CodeW-1:0] FigsCode  = 5'b11011;
    localparam logic [CodeW-1:0] SpaceCode = 5'b00100;

    localparam logic [CharW-1:0] ChLf = 8'h0A;
    localparam logic [CharW-1:0] ChCr = 8'h0D;

    typedef enum logic [1:0] {
        CLS_LTR,
        CLS_FIG,
        CLS_NEU
    } cls_t;

    typedef enum logic {
        CFG_BIT_PERIOD  = 1'b0,
        CFG_STOP_PERIOD = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        cls_t             cls;
        logic [CodeW-1:0] code;
    } lut_t;

    typedef struct packed {
        logic             shift_en;
        logic [CodeW-1:0] shift_code;
        logic [CodeW-1:0] code;
        logic             letters_next;
        logic             after_next;
    } dec_t;

    localparam logic [CodeW-1:0] LetterCodes [26] = '{
        5'b11000, 5'b10011, 5'b01110, 5'b10010, 5'b10000,
        5'b10110, 5'b01011, 5'b00101, 5'b01100, 5'b11010,
        5'b11110, 5'b01001, 5'b00111, 5'b00110, 5'b00011,
        5'b01101, 5'b11101, 5'b01010, 5'b10100, 5'b00001,
        5'b11100, 5'b01111, 5'b11001, 5'b10111, 5'b10101,
        5'b10001
    };

    localparam logic [CodeW-1:0] DigitCodes [10] = '{
        5'b01101, 5'b11101, 5'b11001, 5'b10000, 5'b01010,
        5'b00001, 5'b10101, 5'b11100, 5'b01100, 5'b00011
    };

    function automatic lut_t char_lookup(input logic [CharW-1:0] c);
        lut_t             r;
        logic [CharW-1:0] off;
        r.cls  = CLS_FIG;
        r.code = SpaceCode;
        off    = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            off    = c - 8'h41;
            r.cls  = CLS_LTR;
            r.code = LetterCodes[off[4:0]];
        end else if (c >= 8'h30 && c <= 8'h39) begin
            off    = c - 8'h30;
            r.code = DigitCodes[off[3:0]];
        end else begin
            case (c)
                8'h2D: r.code = 5'b11000;
                8'h3F: r.code = 5'b10011;
                8'h3A: r.code = 5'b01110;
                8'h28: r.code = 5'b11110;
                8'h29: r.code = 5'b01001;
                8'h2E: r.code = 5'b00111;
                8'h2C: r.code = 5'b00110;
                8'h2F: r.code = 5'b10111;
                8'h2B: r.code = 5'b10001;
                ChLf: begin
                    r.cls  = CLS_NEU;
                    r.code = 5'b01000;
                end
                ChCr: begin
                    r.cls  = CLS_NEU;
                    r.code = 5'b00010;
                end
                default: begin
                    r.cls  = CLS_NEU;
                    r.code = SpaceCode;
                end
            endcase
        end
        return r;
    endfunction

    // bit 0 is the start bit, bits 1..5 carry d1..d5, bit 6 is the stop bit
    function automatic logic [FrameW-1:0] frame_bits(input logic [CodeW-1:0] code);
        return {1'b1, code[0], code[1], code[2], code[3], code[4], 1'b0};
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/baudot_fsk_char_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// ITA2 (Baudot) RTTY character encoder with timed key events.
// Input channel (s_*): one ASCII character per item. Result channel (m_*):
// one key event per item (level, duration in ms, last-event flag). Each
// character yields 7 events (start, d1..d5, stop), or 14 when a LTRS/FIGS
// shift character goes out first; the final event carries m_last_event.
// Latency: the first event is loaded into the output register once the
// sequencer advances after the character is taken. Throughput: one event
// per cycle from the output register while m_ready does not stall it; the
// next character is taken in the same cycle as the final event of the
// current one enters the output register, so events flow without gaps.
// Configuration: cfg_we/cfg_index/cfg_data write the bit period (index 0)
// and stop period (index 1); write them only while idle. Periods of 0 act as
// 1 and large values are clipped to 1000 and 1500 ms.
// Reset (aresetn low, synchronous): letters shift assumed, after-space flag
// clear, periods 22 and 33 ms, no event pending.
// When m_ready is low the current event holds and the sequencer stops; the
// input side is ready while idle and again as the final event of a character advances.
module baudot_fsk_char_encoder (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bfce_pkg::CharW-1:0]    s_char_code,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_mark_level,
    output logic [bfce_pkg::DurW-1:0]          m_duration_ms,
    output logic                               m_last_event,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [bfce_pkg::StopPerW-1:0] cfg_data
);
    import bfce_pkg::*;

    logic [BitPerW-1:0]  bit_per_reg;
    logic [StopPerW-1:0] stop_per_reg;
    logic                letters_reg;
    logic                after_reg;

    logic                busy_reg;
    logic                two_reg;
    logic [IdxW-1:0]     idx_reg;
    logic [SeqW-1:0]     seq_reg;

    logic                m_valid_reg;
    logic                m_level_reg;
    logic [DurW-1:0]     m_dur_reg;
    logic                m_last_reg;

    dec_t                dec;
    logic                accept;
    logic                advance;
    logic                ev_last;
    logic                ev_stop;
    logic [BitPerW-1:0]  bit_eff;
    logic [StopPerW-1:0] stop_eff;
    logic [SeqW-1:0]     seq_next;

    bfce_decode u_decode (
        .char_code    (s_char_code),
        .letters_mode (letters_reg),
        .after_space  (after_reg),
        .dec          (dec)
    );

    always_comb begin
        bit_eff = bit_per_reg;
        if (bit_per_reg == '0) begin
            bit_eff = BitPerW'(1);
        end else if (bit_per_reg > BitPerMax) begin
            bit_eff = BitPerMax;
        end
        stop_eff = stop_per_reg;
        if (stop_per_reg == '0) begin
            stop_eff = StopPerW'(1);
        end else if (stop_per_reg > StopPerMax) begin
            stop_eff = StopPerMax;
        end
    end

    assign advance = busy_reg && (!m_valid_reg || m_ready);
    assign ev_last = (idx_reg == (two_reg ? LastIdxTwo : LastIdxOne));
    assign ev_stop = (idx_reg == LastIdxOne) || (idx_reg == LastIdxTwo);
    assign s_ready = !busy_reg || (advance && ev_last);
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (dec.shift_en) begin
            seq_next = {frame_bits(dec.code), frame_bits(dec.shift_code)};
        end else begin
            seq_next = {{FrameW{1'b0}}, frame_bits(dec.code)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_per_reg  <= BitPerReset;
            stop_per_reg <= StopPerReset;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_BIT_PERIOD:  bit_per_reg  <= cfg_data[BitPerW-1:0];
                CFG_STOP_PERIOD: stop_per_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // shift state moves forward when the character is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            letters_reg <= 1'b1;
            after_reg   <= 1'b0;
        end else if (accept) begin
            letters_reg <= dec.letters_next;
            after_reg   <= dec.after_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            two_reg  <= 1'b0;
        end else if (accept) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            two_reg  <= dec.shift_en;
        end else if (advance) begin
            if (ev_last) begin
                busy_reg <= 1'b0;
            end
            idx_reg <= idx_reg + IdxW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            seq_reg <= seq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_level_reg <= seq_reg[idx_reg];
            m_dur_reg   <= ev_stop ? stop_eff : {1'b0, bit_eff};
            m_last_reg  <= ev_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_mark_level  = m_level_reg;
    assign m_duration_ms = m_dur_reg;
    assign m_last_event  = m_last_reg;

    a_accept_starts : assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg && idx_reg == '0)
        else $error("sequencer did not restart on a new item");

    a_idx_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg <= (two_reg ? LastIdxTwo : LastIdxOne))
        else $error("event index ran past the final stop bit");

    a_last_ends : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && ev_last && !accept |=> !busy_reg && m_valid_reg && m_last_reg)
        else $error("final event did not end the character");

    a_dur_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_dur_reg != '0)
        else $error("key event with zero duration");

endmodule

`default_nettype wire

@@ hw/rtl/bfce_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bfce_decode (
    input  wire logic [bfce_pkg::CharW-1:0] char_code,
    input  wire logic                       letters_mode,
    input  wire logic                       after_space,
    output bfce_pkg::dec_t                  dec
);
    import bfce_pkg::*;

    logic [CharW-1:0] c_up;
    lut_t             lut;
    logic             space_like;

    always_comb begin
        // fold lower case
        c_up = char_code;
        if (char_code >= 8'h61 && char_code <= 8'h7A) begin
            c_up = char_code - 8'h20;
        end
        lut        = char_lookup(c_up);
        space_like = (lut.cls == CLS_NEU) && (c_up != ChLf) && (c_up != ChCr);

        dec.code       = lut.code;
        dec.shift_en   = 1'b0;
        dec.shift_code = FigsCode;
        if (letters_mode && lut.cls == CLS_FIG) begin
            dec.shift_en = 1'b1;
        end else if (!letters_mode && lut.cls == CLS_LTR) begin
            dec.shift_en   = 1'b1;
            dec.shift_code = LtrsCode;
        end else if (after_space && lut.cls == CLS_FIG) begin
            dec.shift_en = 1'b1;
        end

        dec.letters_next = letters_mode;
        dec.after_next   = after_space;
        if (lut.cls == CLS_LTR || lut.cls == CLS_FIG) begin
            dec.after_next   = 1'b0;
            dec.letters_next = (lut.cls == CLS_LTR);
        end else if (space_like) begin
            dec.after_next = 1'b1;
        end
    end

endmodule

`default_nettype wire
